/* src/rdkf_pkg.sv */
// Shared types, constants and coefficient table for the RSSI distance Kalman fuser.
`timescale 1ns / 1ps
`default_nettype none

package rdkf_pkg;

   localparam int DIST_FRAC_BITS = 8;
   localparam int DIST_W         = 18;
   localparam int DIST_SHIFT     = 24 - DIST_FRAC_BITS;
   localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(999 << DIST_FRAC_BITS);

   localparam int VAR_W = 18;
   localparam logic [VAR_W-1:0] VAR_ONE = VAR_W'(65536);
   localparam logic [VAR_W-1:0] VAR_MAX = VAR_W'(262143);

   // ln(10) in Q24.
   localparam logic [25:0] LN10_Q24 = 26'd38630967;

   // Shift-add multiplier: A is held, B is scanned one bit per cycle.
   localparam int MUL_A_W   = 36;
   localparam int MUL_B_W   = 28;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // Restoring divider: one quotient bit per cycle.
   localparam int DIV_NUM_W = 35;
   localparam int DIV_DEN_W = 25;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   typedef enum logic [1:0] {
      ACT_LOCAL  = 2'd0,
      ACT_REMOTE = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_QUERY  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CSR_RSSI_1M    = 3'd0,
      CSR_RSSI_10M   = 3'd1,
      CSR_LOCAL_TO   = 3'd2,
      CSR_FRESH_TO   = 3'd3,
      CSR_PROC_NOISE = 3'd4,
      CSR_MEAS_NOISE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [MUL_P_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   // Taylor coefficients 1/k! of e^y in Q24.
   function automatic logic [24:0] taylor_coef(input logic [2:0] idx);
      logic [24:0] c;
      case (idx)
         3'd0:    c = 25'd16777216;
         3'd1:    c = 25'd16777216;
         3'd2:    c = 25'd8388608;
         3'd3:    c = 25'd2796203;
         3'd4:    c = 25'd699051;
         3'd5:    c = 25'd139810;
         3'd6:    c = 25'd23302;
         default: c = 25'd0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* src/rdkf_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rdkf_mul
   import rdkf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_B_W - 1);

   logic [MUL_A_W-1:0]   a_ff;
   logic [MUL_A_W-1:0]   hi_ff;
   logic [MUL_B_W-1:0]   lo_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [MUL_A_W:0]     sum_in;

   always_comb begin
      sum_in = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            a_ff    <= req.a;
            hi_ff   <= '0;
            lo_ff   <= req.b;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            hi_ff  <= sum_in[MUL_A_W:1];
            lo_ff  <= {sum_in[0], lo_ff[MUL_B_W-1:1]};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.prod = {hi_ff, lo_ff};

endmodule

`default_nettype wire

/* src/rdkf_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rdkf_div
   import rdkf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_NUM_W - 1);

   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] q_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W:0]   rem_diff;
   logic                 fits;

   always_comb begin
      rem_sh   = {rem_ff, q_ff[DIV_NUM_W-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      fits     = rem_sh >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            den_ff  <= req.den;
            rem_ff  <= '0;
            q_ff    <= req.num;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            q_ff   <= {q_ff[DIV_NUM_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = q_ff;

endmodule

`default_nettype wire

/* src/rssi_distance_kalman_fuser_unit.sv */
// Top level: RSSI to distance conversion and one-dimensional Kalman fusion.
// A filter update makes nine passes of the serial multiplier and two of the serial divider; with a zero
// gain denominator the second divide is skipped. Without an update, or when the sample seeds the filter,
// the Kalman passes are skipped; clear and query skip all arithmetic.
// One item is worked at a time; the input is free as soon as the result is registered, even
// while that result still waits for the receiver, and a stalled result holds the next one back.
// Synchronous reset restores the register defaults and the filter state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rssi_distance_kalman_fuser_unit
   import rdkf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic signed [7:0] req_rssi,
   input  logic [31:0]       req_now_ms,
   input  logic              req_connected,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [17:0]       rsp_fused_distance,
   output logic              rsp_fused_valid,
   output logic [17:0]       rsp_sample_distance,
   output logic              rsp_sample_used,
   output logic signed [7:0] rsp_local_rssi_out,
   output logic              rsp_local_rssi_valid,
   output logic signed [7:0] rsp_remote_rssi_out,
   output logic              rsp_remote_rssi_valid,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_Y_MUL, ST_Y_DIV, ST_H_MUL,
      ST_DIST, ST_K_DIV, ST_K_EST, ST_K_VAR, ST_FINISH
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic signed [7:0] r1m_ff, r10m_ff;
   logic [15:0]       local_to_ff, fresh_to_ff, q_ff, r_ff;

   // Item fields.
   action_type        act_ff;
   logic signed [7:0] rssi_ff;
   logic [31:0]       now_ff;
   logic              conn_ff;

   // Filter and source state.
   logic [DIST_W-1:0] estimate_ff;
   logic [VAR_W-1:0]  variance_ff;
   logic              started_ff, fused_ok_ff, local_ok_ff, remote_ok_ff;
   logic [31:0]       fused_time_ff, local_time_ff;
   logic signed [7:0] local_level_ff, remote_level_ff;

   // Working registers.
   logic              op_run_ff;
   logic [5:0]        n10_ff;
   logic              dneg_ff;
   logic [7:0]        dmag_ff;
   logic [27:0]       ymag_ff;
   logic              acc_neg_ff;
   logic [35:0]       acc_mag_ff;
   logic [2:0]        idx_ff;
   logic [DIST_W-1:0] sample_ff;
   logic              used_ff;
   logic [18:0]       p_ff;
   logic [16:0]       k_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic [17:0]       o_fused_ff, o_sample_ff;
   logic              o_fvalid_ff, o_used_ff, o_lvalid_ff, o_rvalid_ff;
   logic signed [7:0] o_local_ff, o_remote_ff;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   rdkf_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   rdkf_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   // Path-loss exponent and clamped level difference.
   logic signed [8:0] n10_raw, d_raw;
   logic [5:0]        n10_in;
   logic [7:0]        hi_lim, lo_lim;
   logic signed [9:0] d_clamped;
   logic              dneg_in;
   logic [7:0]        dmag_in;
   logic              remote_use;

   always_comb begin
      n10_raw = 9'(r1m_ff) - 9'(r10m_ff);
      if (n10_raw < 9'sd10) begin
         n10_in = 6'd10;
      end else if (n10_raw > 9'sd60) begin
         n10_in = 6'd60;
      end else begin
         n10_in = n10_raw[5:0];
      end
      hi_lim = {1'b0, n10_in, 1'b0} + {2'b0, n10_in};
      lo_lim = {n10_in, 2'b00};
      d_raw  = 9'(r1m_ff) - 9'(rssi_ff);
      if (10'(d_raw) > $signed({2'b0, hi_lim})) begin
         d_clamped = $signed({2'b0, hi_lim});
      end else if (10'(d_raw) < -$signed({2'b0, lo_lim})) begin
         d_clamped = -$signed({2'b0, lo_lim});
      end else begin
         d_clamped = 10'(d_raw);
      end
      dneg_in    = d_clamped[9];
      dmag_in    = dneg_in ? 8'(-d_clamped) : d_clamped[7:0];
      remote_use = !local_ok_ff || ((now_ff - local_time_ff) > {16'b0, local_to_ff});
   end

   // Horner step: acc = round(acc * y) + coefficient, in sign and magnitude.
   logic [MUL_P_W-1:0] h_round;
   logic [24:0]        coef;
   logic signed [37:0] h_val, h_neg;
   logic               acc_neg_in;
   logic [35:0]        acc_mag_in;

   always_comb begin
      h_round = mul_rsp.prod + MUL_P_W'(64'd8388608);
      coef    = taylor_coef(idx_ff);
      if (acc_neg_ff ^ dneg_ff) begin
         h_val = $signed({13'b0, coef}) - $signed({1'b0, h_round[60:24]});
      end else begin
         h_val = $signed({13'b0, coef}) + $signed({1'b0, h_round[60:24]});
      end
      h_neg      = -h_val;
      acc_neg_in = h_val[37];
      acc_mag_in = acc_neg_in ? h_neg[35:0] : h_val[35:0];
   end

   // Polynomial result rounded to the distance format.
   logic [36:0]       dist_round;
   logic [36:0]       dist_sh;
   logic [DIST_W-1:0] dist_in;

   always_comb begin
      dist_round = {1'b0, acc_mag_ff} + 37'(64'd1 << (DIST_SHIFT - 1));
      dist_sh    = dist_round >> DIST_SHIFT;
      if (acc_neg_ff || acc_mag_ff == '0) begin
         dist_in = '0;
      end else if (dist_sh > 37'(DIST_MAX)) begin
         dist_in = DIST_MAX;
      end else begin
         dist_in = dist_sh[DIST_W-1:0];
      end
   end

   // Kalman arithmetic.
   logic [18:0]        p_in;
   logic [24:0]        k_den;
   logic [34:0]        k_num;
   logic signed [18:0] e_diff, e_neg_val;
   logic               e_neg;
   logic [17:0]        e_mag;
   logic [MUL_P_W-1:0] e_round;
   logic [DIST_W-1:0]  est_in;
   logic [MUL_P_W-1:0] v_round;
   logic [VAR_W-1:0]   var_in;
   logic [16:0]        k_comp;

   always_comb begin
      p_in      = {1'b0, variance_ff} + {3'b0, q_ff};
      k_den     = {6'b0, p_ff} + {1'b0, r_ff, 8'b0};
      k_num     = {p_ff, 16'b0} + {11'b0, k_den[24:1]};
      e_diff    = $signed({1'b0, sample_ff}) - $signed({1'b0, estimate_ff});
      e_neg_val = -e_diff;
      e_neg     = e_diff[18];
      e_mag     = e_neg ? e_neg_val[17:0] : e_diff[17:0];
      e_round   = mul_rsp.prod + MUL_P_W'(32768);
      est_in    = e_neg ? estimate_ff - e_round[33:16] : estimate_ff + e_round[33:16];
      v_round   = mul_rsp.prod + MUL_P_W'(32768);
      var_in    = (v_round[34:16] > {1'b0, VAR_MAX}) ? VAR_MAX : v_round[33:16];
      k_comp    = 17'd65536 - k_ff;
   end

   // Operand selection for the shared serial units.
   always_comb begin
      mul_req.start = !op_run_ff && (state_ff == ST_Y_MUL || state_ff == ST_H_MUL ||
                                     state_ff == ST_K_EST || state_ff == ST_K_VAR);
      unique case (state_ff)
         ST_Y_MUL: begin
            mul_req.a = {10'b0, LN10_Q24};
            mul_req.b = {20'b0, dmag_ff};
         end
         ST_K_EST: begin
            mul_req.a = {19'b0, k_ff};
            mul_req.b = {10'b0, e_mag};
         end
         ST_K_VAR: begin
            mul_req.a = {19'b0, k_comp};
            mul_req.b = {9'b0, p_ff};
         end
         default: begin
            mul_req.a = acc_mag_ff;
            mul_req.b = ymag_ff;
         end
      endcase
      div_req.start = !op_run_ff && (state_ff == ST_Y_DIV ||
                                     (state_ff == ST_K_DIV && k_den != '0));
      if (state_ff == ST_K_DIV) begin
         div_req.num = k_num;
         div_req.den = k_den;
      end else begin
         div_req.num = mul_rsp.prod[DIV_NUM_W-1:0] + DIV_NUM_W'(n10_ff[5:1]);
         div_req.den = {19'b0, n10_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         op_run_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         r1m_ff          <= -8'sd59;
         r10m_ff         <= -8'sd79;
         local_to_ff     <= 16'd3000;
         fresh_to_ff     <= 16'd5000;
         q_ff            <= 16'd3932;
         r_ff            <= 16'd512;
         estimate_ff     <= DIST_MAX;
         variance_ff     <= VAR_ONE;
         started_ff      <= 1'b0;
         fused_ok_ff     <= 1'b0;
         local_ok_ff     <= 1'b0;
         remote_ok_ff    <= 1'b0;
         fused_time_ff   <= '0;
         local_time_ff   <= '0;
         local_level_ff  <= '0;
         remote_level_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_RSSI_1M:    r1m_ff      <= csr_wdata[7:0];
               CSR_RSSI_10M:   r10m_ff     <= csr_wdata[7:0];
               CSR_LOCAL_TO:   local_to_ff <= csr_wdata;
               CSR_FRESH_TO:   fresh_to_ff <= csr_wdata;
               CSR_PROC_NOISE: q_ff        <= csr_wdata;
               CSR_MEAS_NOISE: r_ff        <= csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  act_ff   <= action_type'(req_action);
                  rssi_ff  <= req_rssi;
                  now_ff   <= req_now_ms;
                  conn_ff  <= req_connected;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               n10_ff    <= n10_in;
               dneg_ff   <= dneg_in;
               dmag_ff   <= dmag_in;
               sample_ff <= '0;
               used_ff   <= 1'b0;
               state_ff  <= ST_FINISH;
               unique case (act_ff)
                  ACT_LOCAL: begin
                     if (conn_ff) begin
                        local_level_ff <= rssi_ff;
                        local_ok_ff    <= 1'b1;
                        local_time_ff  <= now_ff;
                        used_ff        <= 1'b1;
                        state_ff       <= ST_Y_MUL;
                     end
                  end
                  ACT_REMOTE: begin
                     remote_level_ff <= rssi_ff;
                     remote_ok_ff    <= 1'b1;
                     used_ff         <= remote_use;
                     state_ff        <= ST_Y_MUL;
                  end
                  ACT_CLEAR: begin
                     local_ok_ff   <= 1'b0;
                     remote_ok_ff  <= 1'b0;
                     started_ff    <= 1'b0;
                     fused_ok_ff   <= 1'b0;
                     estimate_ff   <= DIST_MAX;
                     fused_time_ff <= '0;
                  end
                  default: ;
               endcase
            end
            ST_Y_MUL: begin
               if (!op_run_ff) begin
                  op_run_ff <= 1'b1;
               end else if (mul_rsp.done) begin
                  op_run_ff <= 1'b0;
                  state_ff  <= ST_Y_DIV;
               end
            end
            ST_Y_DIV: begin
               if (!op_run_ff) begin
                  op_run_ff <= 1'b1;
               end else if (div_rsp.done) begin
                  op_run_ff  <= 1'b0;
                  ymag_ff    <= div_rsp.quo[27:0];
                  acc_neg_ff <= 1'b0;
                  acc_mag_ff <= {11'b0, taylor_coef(3'd6)};
                  idx_ff     <= 3'd5;
                  state_ff   <= ST_H_MUL;
               end
            end
            ST_H_MUL: begin
               if (!op_run_ff) begin
                  op_run_ff <= 1'b1;
               end else if (mul_rsp.done) begin
                  op_run_ff  <= 1'b0;
                  acc_neg_ff <= acc_neg_in;
                  acc_mag_ff <= acc_mag_in;
                  idx_ff     <= idx_ff - 1'b1;
                  if (idx_ff == 3'd0) begin
                     state_ff <= ST_DIST;
                  end
               end
            end
            ST_DIST: begin
               sample_ff <= dist_in;
               p_ff      <= p_in;
               if (!used_ff) begin
                  state_ff <= ST_FINISH;
               end else if (!started_ff) begin
                  // The first sample seeds the filter directly.
                  estimate_ff   <= dist_in;
                  variance_ff   <= VAR_ONE;
                  started_ff    <= 1'b1;
                  fused_ok_ff   <= 1'b1;
                  fused_time_ff <= now_ff;
                  state_ff      <= ST_FINISH;
               end else begin
                  state_ff <= ST_K_DIV;
               end
            end
            ST_K_DIV: begin
               if (!op_run_ff) begin
                  if (k_den == '0) begin
                     k_ff     <= '0;
                     state_ff <= ST_K_EST;
                  end else begin
                     op_run_ff <= 1'b1;
                  end
               end else if (div_rsp.done) begin
                  op_run_ff <= 1'b0;
                  k_ff      <= div_rsp.quo[16:0];
                  state_ff  <= ST_K_EST;
               end
            end
            ST_K_EST: begin
               if (!op_run_ff) begin
                  op_run_ff <= 1'b1;
               end else if (mul_rsp.done) begin
                  op_run_ff   <= 1'b0;
                  estimate_ff <= est_in;
                  state_ff    <= ST_K_VAR;
               end
            end
            ST_K_VAR: begin
               if (!op_run_ff) begin
                  op_run_ff <= 1'b1;
               end else if (mul_rsp.done) begin
                  op_run_ff     <= 1'b0;
                  variance_ff   <= var_in;
                  fused_ok_ff   <= 1'b1;
                  fused_time_ff <= now_ff;
                  state_ff      <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  o_fused_ff   <= estimate_ff;
                  o_fvalid_ff  <= conn_ff && fused_ok_ff &&
                                  ((now_ff - fused_time_ff) <= {16'b0, fresh_to_ff});
                  o_sample_ff  <= sample_ff;
                  o_used_ff    <= used_ff;
                  o_local_ff   <= local_ok_ff ? local_level_ff : 8'sd0;
                  o_lvalid_ff  <= local_ok_ff;
                  o_remote_ff  <= remote_ok_ff ? remote_level_ff : 8'sd0;
                  o_rvalid_ff  <= remote_ok_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall             = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_fused_distance    = o_fused_ff;
   assign rsp_fused_valid       = o_fvalid_ff;
   assign rsp_sample_distance   = o_sample_ff;
   assign rsp_sample_used       = o_used_ff;
   assign rsp_local_rssi_out    = o_local_ff;
   assign rsp_local_rssi_valid  = o_lvalid_ff;
   assign rsp_remote_rssi_out   = o_remote_ff;
   assign rsp_remote_rssi_valid = o_rvalid_ff;

   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_rsp.busy)
      else $error("multiplier started while busy");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_Y_DIV || state_ff == ST_K_DIV))
      else $error("divider finished outside a divide step");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_Y_MUL || state_ff == ST_H_MUL ||
                        state_ff == ST_K_EST || state_ff == ST_K_VAR))
      else $error("multiplier finished outside a multiply step");

   a_estimate_range: assert property (@(posedge clock) disable iff (reset)
      estimate_ff <= DIST_MAX)
      else $error("fused estimate above saturation limit");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the RSSI distance Kalman fuser: random and directed items.
`timescale 1ns / 1ps

module testbench;
   import rdkf_pkg::*;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      logic [1:0]        action;
      logic signed [7:0] rssi;
      logic [31:0]       now_ms;
      logic              connected;
   } sample_item;

   typedef struct {
      logic [17:0]       fused_distance;
      logic              fused_valid;
      logic [17:0]       sample_distance;
      logic              sample_used;
      logic signed [7:0] local_rssi;
      logic              local_valid;
      logic signed [7:0] remote_rssi;
      logic              remote_valid;
   } fuser_result;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_action = ACT_QUERY;
   logic signed [7:0] req_rssi = 0;
   logic [31:0] req_now_ms = 0;
   logic req_connected = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [17:0] rsp_fused_distance, rsp_sample_distance;
   logic rsp_fused_valid, rsp_sample_used, rsp_local_rssi_valid, rsp_remote_rssi_valid;
   logic signed [7:0] rsp_local_rssi_out, rsp_remote_rssi_out;
   logic csr_we = 0;
   logic [2:0] csr_index = CSR_RSSI_1M;
   logic [15:0] csr_wdata = 0;

   sample_item  pending_items[$];
   fuser_result expected_results[$];
   int errors = 0;
   int results_seen = 0;
   int unsigned cycle_count = 0;

   // Predictor copy of the registers and the filter state.
   int              cfg_r1m, cfg_r10m;
   int unsigned     cfg_local_to, cfg_fresh_to, cfg_q, cfg_r;
   longint unsigned est, var_q16;
   bit              started, fused_ok, local_ok, remote_ok;
   logic [31:0]     fused_time, local_time;
   logic signed [7:0] local_level, remote_level;

   rssi_distance_kalman_fuser_unit uut (.*);

   always #4 clock = ~clock;

   function automatic longint round_div(longint num, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint mul_round_q24(longint a, longint b);
      longint unsigned ua, ub, m;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      m = (ua * ub + (64'd1 << 23)) >> 24;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned path_loss_distance(int rssi);
      longint coef[7] = '{16777216, 16777216, 8388608, 2796203, 699051, 139810, 23302};
      int n10, d;
      longint y, acc;
      longint unsigned dist_val;
      n10 = cfg_r1m - cfg_r10m;
      d = cfg_r1m - rssi;
      if (n10 < 10) n10 = 10;
      if (n10 > 60) n10 = 60;
      if (d > 3 * n10) d = 3 * n10;
      if (d < -4 * n10) d = -4 * n10;
      y = round_div(longint'(d) * 38630967, n10);
      acc = coef[6];
      for (int i = 5; i >= 0; i--) acc = mul_round_q24(acc, y) + coef[i];
      if (acc <= 0) return 0;
      dist_val = (longint'(acc) + (64'd1 << (DIST_SHIFT - 1))) >> DIST_SHIFT;
      return dist_val > DIST_MAX ? DIST_MAX : dist_val;
   endfunction

   function automatic void kalman_fuse(longint unsigned z, logic [31:0] now);
      longint unsigned p, den, k, v;
      p = var_q16 + cfg_q;
      if (!started) begin
         est = z;
         var_q16 = 65536;
         started = 1;
      end else begin
         den = p + (longint'(cfg_r) << 8);
         k = den == 0 ? 0 : (p * 65536 + den / 2) / den;
         est = longint'(est) + round_div(longint'(k) * (longint'(z) - longint'(est)), 65536);
         v = ((65536 - k) * p + 32768) / 65536;
         var_q16 = v > VAR_MAX ? VAR_MAX : v;
      end
      fused_ok = 1;
      fused_time = now;
   endfunction

   function automatic fuser_result predict_item(sample_item it);
      fuser_result r;
      longint unsigned z = 0;
      bit used = 0;
      case (action_type'(it.action))
         ACT_LOCAL: if (it.connected) begin
            local_level = it.rssi;
            local_ok = 1;
            local_time = it.now_ms;
            z = path_loss_distance(it.rssi);
            kalman_fuse(z, it.now_ms);
            used = 1;
         end
         ACT_REMOTE: begin
            remote_level = it.rssi;
            remote_ok = 1;
            z = path_loss_distance(it.rssi);
            if (!local_ok || (it.now_ms - local_time) > cfg_local_to) begin
               kalman_fuse(z, it.now_ms);
               used = 1;
            end
         end
         ACT_CLEAR: begin
            local_ok = 0;
            remote_ok = 0;
            started = 0;
            fused_ok = 0;
            est = DIST_MAX;
            fused_time = 0;
         end
         default: ;
      endcase
      r.fused_distance = est[17:0];
      r.fused_valid = it.connected && fused_ok && ((it.now_ms - fused_time) <= cfg_fresh_to);
      r.sample_distance = z[17:0];
      r.sample_used = used;
      r.local_rssi = local_ok ? local_level : 8'sd0;
      r.local_valid = local_ok;
      r.remote_rssi = remote_ok ? remote_level : 8'sd0;
      r.remote_valid = remote_ok;
      return r;
   endfunction

   // Predictor: follows register writes and every accepted item.
   always @(posedge clock) begin
      sample_item it;
      if (reset) begin
         cfg_r1m = -59; cfg_r10m = -79; cfg_local_to = 3000; cfg_fresh_to = 5000;
         cfg_q = 3932; cfg_r = 512;
         est = DIST_MAX; var_q16 = 65536;
         started = 0; fused_ok = 0; local_ok = 0; remote_ok = 0;
         fused_time = 0; local_time = 0; local_level = 0; remote_level = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_RSSI_1M:    cfg_r1m = int'($signed(csr_wdata[7:0]));
               CSR_RSSI_10M:   cfg_r10m = int'($signed(csr_wdata[7:0]));
               CSR_LOCAL_TO:   cfg_local_to = csr_wdata;
               CSR_FRESH_TO:   cfg_fresh_to = csr_wdata;
               CSR_PROC_NOISE: cfg_q = csr_wdata;
               CSR_MEAS_NOISE: cfg_r = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            it.action = req_action;
            it.rssi = req_rssi;
            it.now_ms = req_now_ms;
            it.connected = req_connected;
            expected_results.push_back(predict_item(it));
         end
      end
   end

   // Driver: one item from the pending queue at a time, with random gaps.
   int unsigned send_gap = 0;
   bit send_burst = 0;
   always @(posedge clock) begin
      sample_item it;
      if (!reset && (!req_valid || !req_stall)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 0;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_action <= it.action;
            req_rssi <= it.rssi;
            req_now_ms <= it.now_ms;
            req_connected <= it.connected;
            req_valid <= 1;
            if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 12);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Receiver stall, including one long hold-off so the block backs up.
   int unsigned recv_wait = 0;
   int unsigned long_hold = 0;
   bit long_hold_done = 0;
   bit recv_burst = 0;
   always @(posedge clock) begin
      logic next_stall;
      next_stall = 0;
      if (!reset) begin
         if (!long_hold_done && results_seen >= 300) begin
            long_hold_done = 1;
            long_hold = 3000;
         end
         if (long_hold > 0) begin
            long_hold--;
            next_stall = 1;
         end else begin
            if (rsp_valid && !rsp_stall) begin
               if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
               recv_wait = recv_burst ? 0 : $urandom_range(0, 12);
            end
            if (recv_wait > 0) begin
               recv_wait--;
               next_stall = 1;
            end
         end
      end
      rsp_stall <= next_stall;
   end

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Monitor: each accepted result against the oldest expectation.
   always @(posedge clock) begin
      fuser_result e;
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("testbench NOT OK");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result with no item pending, actual distance %0d",
                     $time, rsp_fused_distance);
         end else begin
            e = expected_results.pop_front();
            compare_field("fused_distance", e.fused_distance, rsp_fused_distance);
            compare_field("fused_valid", e.fused_valid, rsp_fused_valid);
            compare_field("sample_distance", e.sample_distance, rsp_sample_distance);
            compare_field("sample_used", e.sample_used, rsp_sample_used);
            compare_field("local_rssi", e.local_rssi, rsp_local_rssi_out);
            compare_field("local_valid", e.local_valid, rsp_local_rssi_valid);
            compare_field("remote_rssi", e.remote_rssi, rsp_remote_rssi_out);
            compare_field("remote_valid", e.remote_valid, rsp_remote_rssi_valid);
         end
      end
   end

   logic [31:0] clock_ms = 0;

   task automatic add_item(action_type act, int rssi, int unsigned step_ms, bit conn);
      sample_item it;
      clock_ms += step_ms;
      it.action = act;
      it.rssi = rssi[7:0];
      it.now_ms = clock_ms;
      it.connected = conn;
      pending_items.push_back(it);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic wait_quiet();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int sel;
      int unsigned step;
      // Per phase: 1 m ref, 10 m ref, local timeout, fresh timeout, Q, R.
      int phase_cfg[6][6] = '{
         '{-59, -79, 3000, 5000, 3932, 512},
         '{127, -128, 0, 0, 0, 1},
         '{-128, 127, 65535, 65535, 65535, 65535},
         '{-40, -45, 1000, 2000, 100, 40},
         '{-70, -100, 500, 65535, 65535, 1},
         '{0, -30, 3000, 5000, 20000, 3000}};
      repeat (11) @(posedge clock);
      reset <= 0;

      // Directed items under the reset settings.
      add_item(ACT_QUERY, 0, 0, 1);
      add_item(ACT_LOCAL, -59, 10, 0);
      add_item(ACT_REMOTE, -128, 100, 0);
      add_item(ACT_REMOTE, 127, 100, 1);
      add_item(ACT_LOCAL, -128, 100, 1);
      add_item(ACT_LOCAL, 127, 100, 1);
      add_item(ACT_LOCAL, -59, 100, 1);
      add_item(ACT_REMOTE, -79, 100, 1);
      add_item(ACT_REMOTE, -70, 3001, 1);
      add_item(ACT_QUERY, 0, 5001, 1);
      add_item(ACT_QUERY, 0, 0, 0);
      add_item(ACT_CLEAR, 5, 1, 1);
      add_item(ACT_QUERY, 0, 1, 1);
      add_item(ACT_REMOTE, -90, 1, 1);
      add_item(ACT_LOCAL, -30, -32'd200 - clock_ms, 1);
      add_item(ACT_REMOTE, -60, 400, 1);
      add_item(ACT_LOCAL, -65, 5000, 1);
      add_item(ACT_CLEAR, -1, 0, 0);
      add_item(ACT_LOCAL, -100, 32'hFFFF_FFFF, 1);

      for (int ph = 0; ph < 6; ph++) begin
         wait_quiet();
         for (int r = 0; r < 6; r++) write_reg(csr_index_type'(r), phase_cfg[ph][r][15:0]);
         for (int n = 0; n < 200; n++) begin
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 49))
               0:       step = $urandom;
               1, 2, 3: step = $urandom_range(0, 70000);
               default: step = $urandom_range(0, 1500);
            endcase
            add_item(sel < 50 ? ACT_LOCAL : sel < 85 ? ACT_REMOTE :
                     sel < 93 ? ACT_QUERY : ACT_CLEAR,
                     $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 255)) - 128 :
                     phase_cfg[ph][0] - int'($urandom_range(0, 80)) + 20,
                     step, $urandom_range(0, 9) != 0);
         end
      end

      wait_quiet();
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
src/rdkf_pkg.sv
src/rdkf_mul.sv
src/rdkf_div.sv
src/rssi_distance_kalman_fuser_unit.sv
sim/testbench.sv
